FILE: design/bsg_pkg.sv
// Shared types, constants and calibration tables of the battery switch guard.
`default_nettype none

package bsg_pkg;

    // Number formats.
    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 16;
    localparam int COEF_BITS = 20;
    localparam int VOLT_BITS = FRAC_BITS + 6;
    localparam int ACC_BITS  = 32;
    localparam int MUL_BITS  = 33;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int CW        = 25;

    // Pin voltage x = round(adc * 3.3 * 2^F / (2^A - 1)), numerator and
    // denominator reduced by their common factor of six.
    localparam longint X_MUL   = (longint'(33) << FRAC_BITS) / 6;
    localparam longint X_DIV   = (longint'(10) * ((longint'(1) << ADC_BITS) - 1)) / 6;
    localparam longint X_OFS   = X_DIV / 2;
    localparam int     X_SHIFT = 44;
    localparam longint X_RECIP = ((longint'(1) << X_SHIFT) + X_DIV - 1) / X_DIV;
    localparam int     X_BITS  = 18;
    localparam int     XN_BITS = 31;

    // Current reply: floor(6600 * adc / (2^A - 1)) - 3320.
    localparam longint C_MUL   = 6600;
    localparam longint C_DIV   = (longint'(1) << ADC_BITS) - 1;
    localparam int     C_SHIFT = 38;
    localparam longint C_RECIP = ((longint'(1) << C_SHIFT) + C_DIV - 1) / C_DIV;
    localparam int     CQ_BITS = 13;
    localparam int     CN_BITS = 25;
    localparam int     C_ZERO  = 3320;

    // Frame identifiers.
    localparam logic [10:0] ID_Q_VOLT = 11'h200;
    localparam logic [10:0] ID_Q_CURR = 11'h201;
    localparam logic [10:0] ID_Q_SW   = 11'h202;
    localparam logic [10:0] ID_ORDER  = 11'h206;
    localparam logic [10:0] ID_OFF_A  = 11'h001;
    localparam logic [10:0] ID_OFF_B  = 11'h002;
    localparam logic [9:0]  REP_VOLT  = 10'h203;
    localparam logic [9:0]  REP_CURR  = 10'h204;
    localparam logic [9:0]  REP_SW    = 10'h205;

    // Order codes.
    localparam logic [7:0] ORD_SW1     = 8'd1;
    localparam logic [7:0] ORD_SW2     = 8'd2;
    localparam logic [7:0] ORD_SW3     = 8'd3;
    localparam logic [7:0] ORD_LIMIT   = 8'd10;
    localparam logic [7:0] ORD_ALL_OFF = 8'd11;

    localparam logic [7:0] LIMIT_RESET  = 8'd20;
    localparam logic [7:0] PERIOD_RESET = 8'd10;

    typedef logic [ADC_BITS-1:0]        t_adc;
    typedef logic signed [VOLT_BITS-1:0] t_volt;
    typedef logic signed [CW-1:0]        t_coef;

    typedef enum logic [2:0] {
        OP_NONE, OP_Q_VOLT, OP_Q_CURR, OP_Q_SW,
        OP_SW_ON, OP_SW_OFF, OP_LIMIT, OP_ALL_OFF
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_XMUL, S_XGET, S_HMUL, S_HADD, S_VFIN, S_CMUL, S_CGET, S_DONE
    } t_bstate;

    // One classified tick as it waits in the queue.
    typedef struct packed {
        logic [2:0][ADC_BITS-1:0] cur;
        logic [3:0][ADC_BITS-1:0] bat;
        logic                     stop;
        t_op                      op;
        logic [2:0]               chan;
        logic [7:0]               arg;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Calibration polynomials c0..c6 in Q4.20: main, battery 1, 2, 3.
    localparam t_coef COEF [4][7] = '{
        '{25'sd16043, 25'sd7969702, 25'sd1161088, -25'sd1223898,
          25'sd661337, -25'sd176161, 25'sd18245},
        '{25'sd12059, 25'sd8358409, 25'sd546203, -25'sd872415,
          25'sd608489, -25'sd188953, 25'sd21391},
        '{25'sd9752, 25'sd8337228, 25'sd622120, -25'sd929667,
          25'sd621386, -25'sd187695, 25'sd20867},
        '{25'sd9961, 25'sd8326532, 25'sd658925, -25'sd941516,
          25'sd619708, -25'sd187066, 25'sd20867}
    };

endpackage

`default_nettype wire

FILE: design/bsg_front.sv
// Front end: accepts a tick transaction and classifies its request frame.
`default_nettype none

module bsg_front (
    input  wire logic          i_tvalid,
    output logic               o_tready,
    input  wire logic [103:0]  i_tdata,
    input  wire logic [11:0]   i_tuser,
    input  wire bsg_pkg::t_qstat i_qstat,
    output logic               o_push,
    output bsg_pkg::t_item     o_item
);
    import bsg_pkg::*;

    logic        rv;
    logic [10:0] id;
    logic [7:0]  b0;
    logic [7:0]  b1;
    t_op         op;

    assign rv = i_tuser[0];
    assign id = i_tuser[11:1];
    assign b0 = i_tdata[92:85];
    assign b1 = i_tdata[100:93];

    // Reduce the request to one operation with its channel and argument.
    always_comb begin
        op = OP_NONE;
        if (rv) begin
            unique case (id) inside
                ID_Q_VOLT: begin
                    if (b0 >= 8'd1 && b0 <= 8'd4) op = OP_Q_VOLT;
                end
                ID_Q_CURR: begin
                    if (b0 >= 8'd1 && b0 <= 8'd3) op = OP_Q_CURR;
                end
                ID_Q_SW: begin
                    if (b0 >= 8'd1 && b0 <= 8'd3) op = OP_Q_SW;
                end
                ID_ORDER: begin
                    unique case (b0) inside
                        ORD_SW1: begin
                            if (b1 == 8'd1)      op = OP_SW_ON;
                            else if (b1 == 8'd0) op = OP_SW_OFF;
                        end
                        ORD_SW2, ORD_SW3: begin
                            op = (b1 == 8'd1) ? OP_SW_ON : OP_SW_OFF;
                        end
                        ORD_LIMIT:   op = OP_LIMIT;
                        ORD_ALL_OFF: op = OP_ALL_OFF;
                        default:     op = OP_NONE;
                    endcase
                end
                ID_OFF_A, ID_OFF_B: op = OP_ALL_OFF;
                default: op = OP_NONE;
            endcase
        end
    end

    // Pack the queue entry.
    always_comb begin
        o_item.cur[0] = i_tdata[11:0];
        o_item.cur[1] = i_tdata[23:12];
        o_item.cur[2] = i_tdata[35:24];
        o_item.bat[0] = i_tdata[47:36];
        o_item.bat[1] = i_tdata[59:48];
        o_item.bat[2] = i_tdata[71:60];
        o_item.bat[3] = i_tdata[83:72];
        o_item.stop   = i_tdata[84];
        o_item.op     = op;
        o_item.chan   = b0[2:0];
        o_item.arg    = b1;
    end

    assign o_tready = !i_qstat.full;
    assign o_push   = i_tvalid && !i_qstat.full;

endmodule

`default_nettype wire

FILE: design/bsg_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none

module bsg_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bsg_pkg::t_item i_item,
    input  wire logic          i_pop,
    output bsg_pkg::t_item     o_item,
    output bsg_pkg::t_qstat    o_qstat
);
    import bsg_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_item        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);

endmodule

`default_nettype wire

FILE: design/bsg_back.sv
// Back end: voltage and current arithmetic, stop handling, orders and result register.
`default_nettype none

module bsg_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [7:0]     i_cfg_wr_data,
    input  wire bsg_pkg::t_item i_item,
    input  wire bsg_pkg::t_qstat i_qstat,
    output logic                o_pop,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output logic [15:0]         o_tdata,
    output logic [11:0]         o_tuser
);
    import bsg_pkg::*;

    t_bstate                    r_state, n_state;
    t_item                      r_item;
    logic [1:0]                 r_bat;
    logic [2:0]                 r_k;
    logic [X_BITS-1:0]          r_x;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [PROD_BITS-1:0] r_prod;
    t_volt                      r_volts [4];
    logic [CQ_BITS-1:0]         r_cur_q;
    logic [2:0]                 r_sw, n_sw;
    logic [7:0]                 r_stop_cnt, n_stop_cnt;
    logic [7:0]                 r_limit, n_limit;
    logic [7:0]                 r_period;
    logic                       r_ovalid;
    logic [15:0]                r_odata, n_odata;
    logic [11:0]                r_ouser, n_ouser;

    logic signed [MUL_BITS-1:0] mul_a, mul_b;
    logic [XN_BITS-1:0]         xn;
    logic [CN_BITS-1:0]         cn;
    logic signed [ACC_BITS-1:0] acc_shr;
    t_volt                      volt_sat;
    logic                       load;
    logic [1:0]                 vidx;
    t_volt                      vsel;
    logic signed [VOLT_BITS+3:0] v10;
    logic signed [9:0]          vq;
    logic signed [CQ_BITS:0]    cdiff;
    logic [1:0]                 cidx;
    logic                       sv, sval, rv;
    logic [9:0]                 rid;
    logic [7:0]                 rval;
    logic signed [VOLT_BITS+3:0] lim_fx;

    // Numerators of the two constant divisions.
    assign xn = XN_BITS'(r_item.bat[r_bat]) * XN_BITS'(X_MUL) + XN_BITS'(X_OFS);
    assign cidx = r_item.chan[1:0] - 2'd1;
    assign cn = CN_BITS'(r_item.cur[cidx]) * CN_BITS'(C_MUL);

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_XMUL: begin
                mul_a = MUL_BITS'(xn);
                mul_b = MUL_BITS'(X_RECIP);
            end
            S_HMUL: begin
                mul_a = MUL_BITS'(r_acc);
                mul_b = MUL_BITS'(r_x);
            end
            S_CMUL: begin
                mul_a = MUL_BITS'(cn);
                mul_b = MUL_BITS'(C_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Q.20 accumulator to Q6.16 volts with saturation.
    always_comb begin
        acc_shr = r_acc >>> (COEF_BITS - FRAC_BITS);
        if (acc_shr < -(ACC_BITS'(1) <<< (VOLT_BITS - 1)))
            volt_sat = {1'b1, {(VOLT_BITS-1){1'b0}}};
        else if (acc_shr > ((ACC_BITS'(1) <<< (VOLT_BITS - 1)) - 1))
            volt_sat = {1'b0, {(VOLT_BITS-1){1'b1}}};
        else
            volt_sat = acc_shr[VOLT_BITS-1:0];
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        load    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_XMUL;
                end
            end
            S_XMUL: n_state = S_XGET;
            S_XGET: n_state = S_HMUL;
            S_HMUL: n_state = S_HADD;
            S_HADD: n_state = (r_k == 3'd0) ? S_VFIN : S_HMUL;
            S_VFIN: n_state = (r_bat == 2'd3) ? S_CMUL : S_XMUL;
            S_CMUL: n_state = S_CGET;
            S_CGET: n_state = S_DONE;
            S_DONE: begin
                if (!r_ovalid || i_tready) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers of the Horner evaluation and the current division.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_bat  <= 2'd0;
        end
        case (r_state)
            S_XGET: begin
                r_x   <= r_prod[X_SHIFT +: X_BITS];
                r_acc <= ACC_BITS'(COEF[r_bat][6]);
                r_k   <= 3'd5;
            end
            S_HADD: begin
                r_acc <= r_prod[FRAC_BITS +: ACC_BITS] + ACC_BITS'(COEF[r_bat][r_k]);
                if (r_k != 3'd0) r_k <= r_k - 3'd1;
            end
            S_VFIN: begin
                r_volts[r_bat] <= volt_sat;
                r_bat          <= r_bat + 2'd1;
            end
            S_CGET: r_cur_q <= r_prod[C_SHIFT +: CQ_BITS];
            default: ;
        endcase
    end

    // Stop handling, replies, orders and limit check of one tick.
    always_comb begin
        vidx  = r_item.chan[1:0] - 2'd1;
        vsel  = r_volts[vidx];
        v10   = ((VOLT_BITS+4)'(vsel) <<< 3) + ((VOLT_BITS+4)'(vsel) <<< 1);
        vq    = v10[FRAC_BITS +: 10];
        cdiff = $signed({1'b0, r_cur_q}) - (CQ_BITS+1)'(C_ZERO);

        n_sw       = r_sw;
        n_stop_cnt = r_stop_cnt;
        n_limit    = r_limit;
        sv   = 1'b0;
        sval = 1'b0;
        rv   = 1'b0;
        rid  = '0;
        rval = '0;

        if (r_item.stop) begin
            if (r_stop_cnt == r_period) begin
                sv         = 1'b1;
                sval       = 1'b1;
                n_stop_cnt = 8'd1;
            end else begin
                n_stop_cnt = r_stop_cnt + 8'd1;
            end
            n_sw = 3'b000;
        end else if (r_stop_cnt != 8'd0) begin
            sv         = 1'b1;
            n_stop_cnt = 8'd0;
        end

        case (r_item.op)
            OP_Q_VOLT: begin
                rv  = 1'b1;
                rid = REP_VOLT;
                if (vq < 0)              rval = 8'd0;
                else if (vq > 10'sd255)  rval = 8'd255;
                else                     rval = vq[7:0];
            end
            OP_Q_CURR: begin
                rv  = 1'b1;
                rid = REP_CURR;
                if (cdiff < 0)                 rval = 8'd0;
                else if (cdiff > 14'sd255)     rval = 8'd255;
                else                           rval = cdiff[7:0];
            end
            OP_Q_SW: begin
                rv   = 1'b1;
                rid  = REP_SW;
                rval = {7'd0, n_sw[vidx]};
            end
            OP_SW_ON:   n_sw[vidx] = 1'b1;
            OP_SW_OFF:  n_sw[vidx] = 1'b0;
            OP_LIMIT:   n_limit = r_item.arg;
            OP_ALL_OFF: n_sw = 3'b000;
            default: ;
        endcase

        // A battery at or above the limit opens its switch.
        lim_fx = $signed({2'b00, n_limit, {FRAC_BITS{1'b0}}});
        for (int i = 0; i < 3; i++) begin
            if ((VOLT_BITS+4)'(r_volts[i+1]) >= lim_fx) n_sw[i] = 1'b0;
        end

        n_odata = {1'b0, rval, (rv ? r_item.chan : 3'd0), sval, n_sw[2], n_sw[1], n_sw[0]};
        n_ouser = {rid, rv, sv};
    end

    // Persistent state and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw       <= 3'b000;
            r_stop_cnt <= 8'd0;
            r_limit    <= LIMIT_RESET;
            r_period   <= PERIOD_RESET;
        end else begin
            if (i_cfg_wr_en) r_period <= i_cfg_wr_data;
            if (load) begin
                r_sw       <= n_sw;
                r_stop_cnt <= n_stop_cnt;
                r_limit    <= n_limit;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (load) r_ovalid <= 1'b1;
        else if (i_tready) r_ovalid <= 1'b0;
        if (load) begin
            r_odata <= n_odata;
            r_ouser <= n_ouser;
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = r_odata;
    assign o_tuser  = r_ouser;

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && !i_qstat.empty)
        else $error("queue popped outside idle");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HADD) |-> (r_k <= 3'd5))
        else $error("Horner index out of range");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_ovalid || i_tready))
        else $error("result register overwritten");
    a_stop_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata[3]) |-> r_ouser[0])
        else $error("stop value without stop frame");
    a_rep_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_ouser[1]) |-> (r_ouser[11:2] == 10'd0))
        else $error("reply id without reply");
`endif

endmodule

`default_nettype wire

FILE: design/battery_switch_guard_unit.sv
// Top level of the battery switch guard: front end, queue and back end.
// One shared 33x33 multiplier runs four sixth-order Horner evaluations and one
// current step per tick; the back end takes the next tick from the queue only
// after the result of the last one is loaded into its result register.
// The input side takes up to two further ticks into the queue while one is at work.
// Synchronous active-low reset: switches off, stop counter zero, limit 20 V, period 10.
`default_nettype none

module battery_switch_guard_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [7:0]   i_cfg_wr_data,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // adc_current1, adc_current2, adc_current3, adc_main_battery, adc_battery1,
    // adc_battery2, adc_battery3 (12 bits each), stop_level, request_byte0,
    // request_byte1, zero fill.
    input  wire logic [103:0] i_s_axis_tdata,
    // request_valid, request_id (11 bits).
    input  wire logic [11:0]  i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // switch1_on, switch2_on, switch3_on, stop_frame_value, reply_index (3),
    // reply_value (8), zero fill.
    output logic [15:0]       o_m_axis_tdata,
    // stop_frame_valid, reply_valid, reply_id (10 bits).
    output logic [11:0]       o_m_axis_tuser
);
    import bsg_pkg::*;

    t_item  push_item;
    t_item  head_item;
    t_qstat qstat;
    logic   push;
    logic   pop;

    bsg_front u_front (
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_item   (push_item)
    );

    bsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    bsg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item        (head_item),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_tvalid      (o_m_axis_tvalid),
        .i_tready      (i_m_axis_tready),
        .o_tdata       (o_m_axis_tdata),
        .o_tuser       (o_m_axis_tuser)
    );

endmodule

`default_nettype wire
